// File: rtl/core/fcfl_pkg.sv
// ----------------------------------------------------------------------------
// fcfl_pkg
// Shared types and constants of the fixed chunk free list allocator.
// ----------------------------------------------------------------------------
package fcfl_pkg;

    localparam int COUNT_W  = 9;
    localparam int SIZE_W   = 16;
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 24;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE  = 2'd1;

    localparam logic [COUNT_W-1:0] RST_CHUNK_COUNT = 9'd256;
    localparam logic [SIZE_W-1:0]  RST_CHUNK_SIZE  = 16'd4;

    typedef struct packed
    {
        logic [COUNT_W-1:0] chunk_count;
        logic [SIZE_W-1:0]  chunk_size;
    } cfg_t;

endpackage

// File: rtl/core/fcfl_link_mem.sv
// ----------------------------------------------------------------------------
// fcfl_link_mem
// Link store of the free list: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcfl_link_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 9
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/fcfl_cfg_regs.sv
// ----------------------------------------------------------------------------
// fcfl_cfg_regs
// Configuration registers: chunk count and chunk size.
// ----------------------------------------------------------------------------
module fcfl_cfg_regs
    import fcfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [COUNT_W-1:0] chunk_count_reg;
    logic [COUNT_W-1:0] chunk_count_next;
    logic [SIZE_W-1:0]  chunk_size_reg;
    logic [SIZE_W-1:0]  chunk_size_next;

    always_comb
    begin
        chunk_count_next = chunk_count_reg;
        chunk_size_next  = chunk_size_reg;
        if (wr_valid)
        begin
            case (wr_index)
                CFG_CHUNK_COUNT: chunk_count_next = wr_data[COUNT_W-1:0];
                CFG_CHUNK_SIZE:  chunk_size_next  = wr_data[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_count_reg <= RST_CHUNK_COUNT;
            chunk_size_reg  <= RST_CHUNK_SIZE;
        end
        else
        begin
            chunk_count_reg <= chunk_count_next;
            chunk_size_reg  <= chunk_size_next;
        end
    end

    assign cfg.chunk_count = chunk_count_reg;
    assign cfg.chunk_size  = chunk_size_reg;

endmodule

// File: rtl/core/fixed_chunk_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator
// Pool of equal-size chunks handed out from a LIFO free list.
// ----------------------------------------------------------------------------
// Request channel (in_valid/in_stall): cmd selects allocate or free, and
// chunk_index names the chunk to free. One result beat follows every request
// on the response channel (out_valid/out_stall): status, granted_index and
// byte_offset = granted_index * chunk_size.
// Fresh chunks come from a counter; freed chunks are pushed on a linked list
// whose links sit in a one-port-read, one-port-write memory.
// The result is registered when the request is accepted.
// A free, an allocate from the counter and a failed request leave the block
// ready for the next request; an allocate from the list first passes through
// S_POP, as the new head comes from the registered read of the link memory.
// A new request is taken only once the response register is free or being
// drained, so a stalled receiver holds off the request side.
// Reset empties the list, clears the counter and loads chunk_count 256 and
// chunk_size 4. Configuration beats (cfg_valid/cfg_ready) are always taken;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator
    import fcfl_pkg::*;
#(
    parameter int MAX_CHUNKS = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  logic [INDEX_W-1:0]    chunk_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [INDEX_W-1:0]    granted_index,
    output logic [OFFSET_W-1:0]   byte_offset,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int LNK_W  = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W  = (LNK_W > COUNT_W) ? LNK_W : COUNT_W;
    localparam int PROD_W = LNK_W + SIZE_W;

    typedef enum logic
    {
        S_IDLE,
        S_POP
    } state_t;

    cfg_t cfg;

    state_t              state_reg;
    state_t              state_next;
    logic [LNK_W-1:0]    head_reg;
    logic [LNK_W-1:0]    head_next;
    logic [LNK_W-1:0]    fresh_reg;
    logic [LNK_W-1:0]    fresh_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [INDEX_W-1:0]  granted_reg;
    logic [INDEX_W-1:0]  granted_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;

    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  fresh_ext;
    logic              head_valid;
    logic              out_free;
    logic              accept;
    logic [LNK_W-1:0]  granted;
    logic [PROD_W-1:0] product;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic              mem_re;
    logic [LNK_W-1:0]  mem_rdata;

    fcfl_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fcfl_link_mem #(
        .DEPTH  (MAX_CHUNKS),
        .ADDR_W (IDX_W),
        .DATA_W (LNK_W)
    ) u_link_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (head_reg),
        .rd_en   (mem_re),
        .rd_addr (head_reg[IDX_W-1:0]),
        .rd_data (mem_rdata)
    );

    assign cfg_ready = 1'b1;

    assign limit = (CMP_W'(cfg.chunk_count) > CMP_W'(MAX_CHUNKS)) ?
                   CMP_W'(MAX_CHUNKS) : CMP_W'(cfg.chunk_count);
    assign idx_ext    = CMP_W'(chunk_index);
    assign fresh_ext  = CMP_W'(fresh_reg);
    assign head_valid = head_reg < LNK_W'(MAX_CHUNKS);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign mem_waddr = idx_ext[IDX_W-1:0];

    assign product = PROD_W'(granted) * PROD_W'(cfg.chunk_size);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        offset_next    = offset_reg;
        granted        = '0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    if (cmd == CMD_ALLOC)
                    begin
                        if (head_valid)
                        begin
                            granted    = head_reg;
                            mem_re     = 1'b1;
                            state_next = S_POP;
                        end
                        else if (fresh_ext < limit)
                        begin
                            granted    = fresh_reg;
                            fresh_next = fresh_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                    else
                    begin
                        if (idx_ext >= limit)
                        begin
                            status_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            head_next = idx_ext[LNK_W-1:0];
                        end
                    end
                    granted_next = INDEX_W'(granted);
                    offset_next  = OFFSET_W'(product);
                end
            end
            S_POP:
            begin
                head_next  = mem_rdata;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= LNK_W'(MAX_CHUNKS);
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            granted_reg   <= '0;
            offset_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            granted_reg   <= granted_next;
            offset_reg    <= offset_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign byte_offset   = offset_reg;

endmodule

// File: rtl/core/fcfl_checker.sv
// ----------------------------------------------------------------------------
// fcfl_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fcfl_checker
    import fcfl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [STATUS_W-1:0] status,
    input logic [INDEX_W-1:0]  granted_index,
    input logic [OFFSET_W-1:0] byte_offset
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(granted_index) && $stable(byte_offset))
        else $error("response beat changed while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request gave no response beat");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (granted_index == '0) && (byte_offset == '0))
        else $error("failed request returned a chunk");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_EMPTY) || (status == ST_BAD_INDEX))
        else $error("undefined status code");

endmodule

bind fixed_chunk_free_list_allocator fcfl_checker u_fcfl_checker (.*);

// File: tb/fixed_chunk_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator_test
// Self-checking bench for the chunk pool allocator.
// ----------------------------------------------------------------------------
// A table of directed requests covers the first grants, empty and bad-index
// results, a zero count, a saturated count, a count lowered while chunks sit
// on the list, and a zero chunk size. Eight random phases follow, each setting
// a count, size and idling pattern. Every request beat is run through
// a pool model kept in the bench, and every result beat is checked against
// the oldest outstanding grant. Random frees never push a chunk that is
// already listed, so the list stays sound and the pool keeps running dry,
// except in the last phase, where double frees are made on purpose.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator_test;
    import fcfl_pkg::*;

    localparam int POOL_MAX    = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 8;
    localparam logic [COUNT_W-1:0] NULL_LINK = 9'd256;

    localparam int PH_COUNT [NUM_PHASES] = '{256, 1, 7, 300, 16, 2, 64, 256};
    localparam int PH_SIZE  [NUM_PHASES] = '{4, 65535, 1, 32769, 0, 3, 4660, 43981};

    typedef struct packed
    {
        status_t               st;
        logic [INDEX_W-1:0]    gi;
        logic [OFFSET_W-1:0]   off;
    } grant_t;

    typedef struct
    {
        logic                  is_cfg;
        cmd_t                  c;
        logic [INDEX_W-1:0]    idx;
        logic                  typed;
        grant_t                res;
        logic [CFG_IDX_W-1:0]  sel;
        logic [CFG_DATA_W-1:0] wdata;
    } dir_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  cmd         = 1'b0;
    logic [INDEX_W-1:0]    chunk_index = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    granted_index;
    logic [OFFSET_W-1:0]   byte_offset;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // pool model
    logic [COUNT_W-1:0]    link_mem [POOL_MAX];
    logic                  listed   [POOL_MAX];
    logic [COUNT_W-1:0]    head_link  = NULL_LINK;
    logic [COUNT_W-1:0]    fresh_cnt  = '0;
    logic [COUNT_W-1:0]    pool_count = RST_CHUNK_COUNT;
    logic [SIZE_W-1:0]     chunk_sz   = RST_CHUNK_SIZE;

    grant_t                grant_q [$];
    logic [INDEX_W-1:0]    held_q  [$];
    dir_row_t              dir_tab [$];

    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    mismatches     = 0;
    int                    cycle_cnt      = 0;
    logic                  hold_go        = 1'b0;
    int                    hold_left      = 0;

    fixed_chunk_free_list_allocator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .chunk_index   (chunk_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_index (granted_index),
        .byte_offset   (byte_offset),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    function automatic grant_t pool_step(input cmd_t c, input logic [INDEX_W-1:0] idx);
        grant_t             r;
        logic [COUNT_W-1:0] lim;
        lim = (pool_count > NULL_LINK) ? NULL_LINK : pool_count;
        r.st  = ST_OK;
        r.gi  = '0;
        r.off = '0;
        if (c == CMD_ALLOC)
        begin
            if (head_link < NULL_LINK)
            begin
                r.gi = head_link[INDEX_W-1:0];
                head_link = link_mem[r.gi];
                listed[r.gi] = 1'b0;
            end
            else if (fresh_cnt < lim)
            begin
                r.gi = fresh_cnt[INDEX_W-1:0];
                fresh_cnt = fresh_cnt + 1'b1;
            end
            else
                r.st = ST_EMPTY;
            if (r.st == ST_OK)
                r.off = r.gi * chunk_sz;
        end
        else if ({1'b0, idx} >= lim)
            r.st = ST_BAD_INDEX;
        else
        begin
            link_mem[idx] = head_link;
            head_link = {1'b0, idx};
            listed[idx] = 1'b1;
        end
        return r;
    endfunction

    function automatic dir_row_t req_row(input cmd_t c, input logic [INDEX_W-1:0] idx);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.c      = c;
        row.idx    = idx;
        row.typed  = 1'b0;
        row.res    = '0;
        row.sel    = CFG_CHUNK_COUNT;
        row.wdata  = '0;
        return row;
    endfunction

    function automatic dir_row_t req_chk(input cmd_t c, input logic [INDEX_W-1:0] idx,
                                         input status_t st, input logic [INDEX_W-1:0] gi,
                                         input logic [OFFSET_W-1:0] off);
        dir_row_t row;
        row        = req_row(c, idx);
        row.typed  = 1'b1;
        row.res.st  = st;
        row.res.gi  = gi;
        row.res.off = off;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
                                         input logic [CFG_DATA_W-1:0] wdata);
        dir_row_t row;
        row        = req_row(CMD_ALLOC, '0);
        row.is_cfg = 1'b1;
        row.sel    = sel;
        row.wdata  = wdata;
        return row;
    endfunction

    task automatic send_req(input cmd_t c, input logic [INDEX_W-1:0] idx, input logic typed,
                            input grant_t typed_res, output grant_t res);
        int hits [$];
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        chunk_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        res = pool_step(c, idx);
        grant_q.push_back(typed ? typed_res : res);
        if (res.st == ST_OK)
        begin
            if (c == CMD_ALLOC)
                held_q.push_back(res.gi);
            else
            begin
                hits = held_q.find_first_index(x) with (x == idx);
                if (hits.size() != 0)
                    held_q.delete(hits[0]);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] wdata);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= wdata;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == CFG_CHUNK_COUNT)
            pool_count = wdata[COUNT_W-1:0];
        else if (sel == CFG_CHUNK_SIZE)
            chunk_sz = wdata;
        @(posedge clk);
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: random stall, long hold-off on request, beat check
    always @(posedge clk)
    begin : result_side
        grant_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat: status %0d index %0d offset %0d",
                             status, granted_index, byte_offset);
            end
            else
            begin
                want = grant_q.pop_front();
                if (status !== want.st || granted_index !== want.gi
                    || byte_offset !== want.off)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.st, want.gi, want.off,
                                 status, granted_index, byte_offset);
                end
            end
        end
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        grant_t             res;
        cmd_t               c;
        logic [INDEX_W-1:0] idx;
        int                 roll;
        int                 mode;
        logic               double_ok;

        foreach (link_mem[i])
        begin
            link_mem[i] = '0;
            listed[i]   = 1'b0;
        end

        dir_tab.push_back(req_chk(CMD_ALLOC, 8'hFF, ST_OK, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_ALLOC, 8'h00, ST_OK, 8'd1, 24'd4));
        dir_tab.push_back(req_chk(CMD_FREE, 8'hFF, ST_OK, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_ALLOC, 8'hA5, ST_OK, 8'd255, 24'd1020));
        dir_tab.push_back(req_chk(CMD_FREE, 8'h00, ST_OK, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_FREE, 8'h01, ST_OK, 8'd0, 24'd0));
        dir_tab.push_back(req_row(CMD_ALLOC, 8'h5A));
        dir_tab.push_back(req_row(CMD_ALLOC, 8'h80));
        dir_tab.push_back(req_row(CMD_ALLOC, 8'h7F));
        dir_tab.push_back(cfg_row(CFG_CHUNK_COUNT, 16'd3));
        dir_tab.push_back(req_chk(CMD_ALLOC, 8'h00, ST_EMPTY, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_FREE, 8'h03, ST_BAD_INDEX, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_FREE, 8'hFF, ST_BAD_INDEX, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_FREE, 8'h02, ST_OK, 8'd0, 24'd0));
        dir_tab.push_back(req_row(CMD_ALLOC, 8'h00));
        dir_tab.push_back(cfg_row(CFG_CHUNK_COUNT, 16'd0));
        dir_tab.push_back(req_chk(CMD_FREE, 8'h00, ST_BAD_INDEX, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_ALLOC, 8'h00, ST_EMPTY, 8'd0, 24'd0));
        // 511 after masking, saturates to the full pool
        dir_tab.push_back(cfg_row(CFG_CHUNK_COUNT, 16'hFFFF));
        dir_tab.push_back(cfg_row(CFG_CHUNK_SIZE, 16'hFFFF));
        dir_tab.push_back(req_chk(CMD_FREE, 8'd200, ST_OK, 8'd0, 24'd0));
        dir_tab.push_back(req_chk(CMD_FREE, 8'd255, ST_OK, 8'd0, 24'd0));
        // listed chunks above the new count are still handed out
        dir_tab.push_back(cfg_row(CFG_CHUNK_COUNT, 16'd2));
        dir_tab.push_back(req_row(CMD_ALLOC, 8'h00));
        dir_tab.push_back(req_row(CMD_ALLOC, 8'h00));
        dir_tab.push_back(req_chk(CMD_ALLOC, 8'h00, ST_EMPTY, 8'd0, 24'd0));
        dir_tab.push_back(cfg_row(CFG_CHUNK_SIZE, 16'd0));
        dir_tab.push_back(req_chk(CMD_FREE, 8'h01, ST_OK, 8'd0, 24'd0));
        dir_tab.push_back(req_row(CMD_ALLOC, 8'h00));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                wait_idle();
                write_reg(dir_tab[i].sel, dir_tab[i].wdata);
            end
            else
                send_req(dir_tab[i].c, dir_tab[i].idx, dir_tab[i].typed, dir_tab[i].res, res);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_reg(CFG_CHUNK_COUNT, CFG_DATA_W'(PH_COUNT[p]));
            write_reg(CFG_CHUNK_SIZE, CFG_DATA_W'(PH_SIZE[p]));
            mode = p % 4;
            send_idle_pct = (mode == 1) ? 73 : (mode == 3) ? 27 : 0;
            recv_stall_pct <= (mode == 2) ? 73 : (mode == 3) ? 27 : 0;
            double_ok = (p == NUM_PHASES - 1);
            if (p == 0)
            begin
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            if (double_ok)
            begin
                send_req(CMD_ALLOC, 8'($urandom_range(255)), 1'b0, '0, res);
                if (res.st == ST_OK)
                begin
                    idx = res.gi;
                    send_req(CMD_FREE, idx, 1'b0, '0, res);
                    send_req(CMD_FREE, idx, 1'b0, '0, res);
                end
            end
            repeat (PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                idx  = 8'($urandom_range(255));
                if (roll < 8)
                    c = CMD_FREE;
                else if (roll < 52 && held_q.size() != 0)
                begin
                    c   = CMD_FREE;
                    idx = held_q[$urandom_range(held_q.size() - 1)];
                end
                else
                    c = CMD_ALLOC;
                // pushing a listed chunk would close a loop in the list
                if (c == CMD_FREE && !double_ok && listed[idx])
                    c = CMD_ALLOC;
                send_req(c, idx, 1'b0, '0, res);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
